@@ design/clut_pkg.sv @@
`timescale 1ns / 1ps
package clut_pkg;

  localparam int unsigned DefTableEntries = 64;
  localparam int unsigned DefWordsPerLine = 8;
  localparam int unsigned DefCountBits    = 32;

  localparam logic [63:0] CutoffReset = 64'd17179869184;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_EVICT = 2'd2;

  localparam logic [1:0] STATUS_EVICTED  = 2'd0;
  localparam logic [1:0] STATUS_NO_ENTRY = 2'd1;
  localparam logic [1:0] STATUS_BAD_MODE = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  localparam logic [5:0] LOG2_OF_ZERO = 6'd63;

  typedef struct packed {
    logic        valid;
    logic [1:0]  mode;
    logic [63:0] key;
    logic [63:0] start;
    logic        found;
    logic        free_found;
  } clut_tok_t;

  typedef struct packed {
    logic        en;
    logic        is_read;
    logic [63:0] key;
    logic [63:0] now;
  } clut_alloc_t;

  function automatic logic [5:0] floor_log2(input logic [63:0] v);
    logic [5:0] r;
    r = LOG2_OF_ZERO;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] count_ones(input logic [63:0] m);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      n = n + 7'(m[i]);
    end
    return n;
  endfunction

endpackage

@@ design/clut_cell.sv @@
`timescale 1ns / 1ps
module clut_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW = 6,
  parameter int unsigned WORDS_PER_LINE = 8,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  clut_pkg::clut_tok_t       tin,
  input  logic [COUNT_BITS-1:0]     tin_rd,
  input  logic [COUNT_BITS-1:0]     tin_wr,
  input  logic [WORDS_PER_LINE-1:0] tin_marks,
  input  logic [IW-1:0]             tin_free_idx,
  output clut_pkg::clut_tok_t       tout,
  output logic [COUNT_BITS-1:0]     tout_rd,
  output logic [COUNT_BITS-1:0]     tout_wr,
  output logic [WORDS_PER_LINE-1:0] tout_marks,
  output logic [IW-1:0]             tout_free_idx,
  input  clut_pkg::clut_alloc_t     alloc,
  input  logic [IW-1:0]             alloc_idx,
  input  logic [WORDS_PER_LINE-1:0] alloc_marks
);
  import clut_pkg::*;

  logic                      valid_r;
  logic [63:0]               key_r;
  logic [63:0]               start_r;
  logic [COUNT_BITS-1:0]     rd_r;
  logic [COUNT_BITS-1:0]     wr_r;
  logic [WORDS_PER_LINE-1:0] marks_r;

  clut_tok_t                 tok_r, tok_nxt;
  logic [COUNT_BITS-1:0]     trd_r, trd_nxt, twr_r, twr_nxt;
  logic [WORDS_PER_LINE-1:0] tmk_r, tmk_nxt;
  logic [IW-1:0]             tfi_r, tfi_nxt;
  logic                      hit, mine;

  assign hit  = tin.valid && valid_r && (key_r == tin.key);
  assign mine = alloc.en && (alloc_idx == IW'(IDX));

  always_comb begin
    tok_nxt = tin;
    trd_nxt = tin_rd;
    twr_nxt = tin_wr;
    tmk_nxt = tin_marks;
    tfi_nxt = tin_free_idx;
    if (hit) begin
      tok_nxt.found = 1'b1;
      if (tin.mode == MODE_EVICT) begin
        tok_nxt.start = start_r;
        trd_nxt = rd_r;
        twr_nxt = wr_r;
        tmk_nxt = marks_r;
      end
    end
    if (tin.valid && !valid_r && !tin.free_found) begin
      tok_nxt.free_found = 1'b1;
      tfi_nxt = IW'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (mine) begin
        valid_r <= 1'b1;
      end else if (hit && tin.mode == MODE_EVICT) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    trd_r <= trd_nxt;
    twr_r <= twr_nxt;
    tmk_r <= tmk_nxt;
    tfi_r <= tfi_nxt;
    if (mine) begin
      key_r   <= alloc.key;
      start_r <= alloc.now;
      rd_r    <= COUNT_BITS'(alloc.is_read);
      wr_r    <= COUNT_BITS'(!alloc.is_read);
      marks_r <= alloc_marks;
    end else if (hit) begin
      unique case (tin.mode)
        MODE_READ: begin
          marks_r <= marks_r | tin_marks;
          if (rd_r != '1) begin
            rd_r <= rd_r + COUNT_BITS'(1);
          end
        end
        MODE_WRITE: begin
          marks_r <= marks_r | tin_marks;
          if (wr_r != '1) begin
            wr_r <= wr_r + COUNT_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign tout          = tok_r;
  assign tout_rd       = trd_r;
  assign tout_wr       = twr_r;
  assign tout_marks    = tmk_r;
  assign tout_free_idx = tfi_r;

endmodule

@@ design/cache_line_usage_tracker_top.sv @@
`timescale 1ns / 1ps
// Cache line usage tracker.
// Input channel (in_valid/in_ready) carries one cache access transaction:
// mode, target address, line address and current cycle. Result channel
// (out_valid/out_ready) carries a status and, for a recorded eviction, the
// floor log2 of read count, write count and age plus the touched word count.
// Accesses at or above the cutoff register (APB, byte address 0) give no
// result; reads and writes of tracked or newly placed lines give none either.
// Each transaction walks a row of TABLE_ENTRIES cells, one cell per cycle,
// and the input is not ready while it walks. A read or write that tracks or
// places its line then returns to idle; an eviction or a read or write that
// finds the table full goes on to the finish state, as does an invalid mode
// at once. Once the output register is free, the finish state loads it and
// returns to idle, so the input is ready again. Ignored accesses stay idle.
// The input is taken only while no transaction walks the row.
// A finished result waits in the output register while the receiver stalls;
// the next transaction may be accepted and walked meanwhile, and it holds
// its own result until the output register frees up.
// Reset empties the table and sets the cutoff to 16 GiB.
module cache_line_usage_tracker_top #(
  parameter int unsigned TABLE_ENTRIES  = clut_pkg::DefTableEntries,
  parameter int unsigned WORDS_PER_LINE = clut_pkg::DefWordsPerLine,
  parameter int unsigned COUNT_BITS     = clut_pkg::DefCountBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_target_address,
  input  logic [63:0] in_line_address,
  input  logic [63:0] in_current_cycle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_read_log2,
  output logic [5:0]  out_write_log2,
  output logic [5:0]  out_age_log2,
  output logic [3:0]  out_words_touched,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import clut_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned N = TABLE_ENTRIES;
  localparam int unsigned W = WORDS_PER_LINE;
  localparam int unsigned CB = COUNT_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FIN} state_t;

  state_t      state_r;
  logic [63:0] cutoff_r;

  clut_tok_t   tk    [N+1];
  logic [CB-1:0] trd [N+1];
  logic [CB-1:0] twr [N+1];
  logic [W-1:0]  tmk [N+1];
  logic [IW-1:0] tfi [N+1];
  logic [N-1:0]  tok_vld;

  logic [W-1:0]  acc_marks_r;
  logic          acc_rd_r;
  logic [63:0]   acc_now_r;
  logic [63:0]   word_off;
  logic [W-1:0]  word_mark;

  logic [1:0]    fin_status_r;
  logic [CB-1:0] fin_rd_r, fin_wr_r;
  logic [63:0]   fin_age_r;
  logic [W-1:0]  fin_marks_r;

  logic          accept, ignored, out_free;
  clut_tok_t     last;
  clut_alloc_t   alloc;
  logic [6:0]    ones;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? 64'd0 : cutoff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CutoffReset;
    end else if (psel && penable && pwrite && !paddr[3]) begin
      cutoff_r <= pwdata;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ignored  = (in_target_address >= cutoff_r);
  assign out_free = !out_valid || out_ready;
  assign word_off = (in_target_address - in_line_address) >> 3;

  always_comb begin
    word_mark = '0;
    for (int i = 0; i < W; i++) begin
      if (word_off == 64'(i)) begin
        word_mark[i] = 1'b1;
      end
    end
  end

  always_comb begin
    tk[0].valid      = accept && !ignored &&
                       (in_mode == MODE_READ || in_mode == MODE_WRITE ||
                        in_mode == MODE_EVICT);
    tk[0].mode       = in_mode;
    tk[0].key        = in_line_address;
    tk[0].start      = '0;
    tk[0].found      = 1'b0;
    tk[0].free_found = 1'b0;
    trd[0] = '0;
    twr[0] = '0;
    tmk[0] = word_mark;
    tfi[0] = '0;
  end

  assign last = tk[N];

  always_comb begin
    alloc.en      = (state_r == ST_WALK) && last.valid && !last.found &&
                    last.free_found && (last.mode != MODE_EVICT);
    alloc.is_read = acc_rd_r;
    alloc.key     = last.key;
    alloc.now     = acc_now_r;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    clut_cell #(
      .IDX(g), .IW(IW), .WORDS_PER_LINE(W), .COUNT_BITS(CB)
    ) u_cell (
      .clk(clk), .rst_n(rst_n),
      .tin(tk[g]), .tin_rd(trd[g]), .tin_wr(twr[g]), .tin_marks(tmk[g]),
      .tin_free_idx(tfi[g]),
      .tout(tk[g+1]), .tout_rd(trd[g+1]), .tout_wr(twr[g+1]),
      .tout_marks(tmk[g+1]), .tout_free_idx(tfi[g+1]),
      .alloc(alloc), .alloc_idx(tfi[N]), .alloc_marks(acc_marks_r)
    );
    assign tok_vld[g] = tk[g+1].valid;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_marks_r <= word_mark;
      acc_rd_r    <= (in_mode == MODE_READ);
      acc_now_r   <= in_current_cycle;
    end
  end

  assign ones = count_ones(64'(fin_marks_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state_r != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && !ignored) begin
            if (tk[0].valid) begin
              state_r <= ST_WALK;
            end else begin
              fin_status_r <= STATUS_BAD_MODE;
              state_r      <= ST_FIN;
            end
          end
        end
        ST_WALK: begin
          if (last.valid) begin
            fin_rd_r    <= trd[N];
            fin_wr_r    <= twr[N];
            fin_age_r   <= acc_now_r - last.start;
            fin_marks_r <= tmk[N];
            if (last.mode == MODE_EVICT) begin
              fin_status_r <= last.found ? STATUS_EVICTED : STATUS_NO_ENTRY;
              state_r      <= ST_FIN;
            end else if (!last.found && !last.free_found) begin
              fin_status_r <= STATUS_FULL;
              state_r      <= ST_FIN;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= fin_status_r;
            if (fin_status_r == STATUS_EVICTED) begin
              out_read_log2     <= floor_log2(64'(fin_rd_r));
              out_write_log2    <= floor_log2(64'(fin_wr_r));
              out_age_log2      <= floor_log2(fin_age_r);
              out_words_touched <= ones[3:0];
            end else begin
              out_read_log2     <= '0;
              out_write_log2    <= '0;
              out_age_log2      <= '0;
              out_words_touched <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one transaction in the cell row");

  a_token_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_vld != '0) |-> (state_r == ST_WALK))
    else $error("cell row busy outside of walk");

  a_alloc_new: assert property (@(posedge clk) disable iff (!rst_n)
    alloc.en |-> (!last.found && last.mode != MODE_EVICT))
    else $error("entry placed for a tracked line");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && !last.valid) |=> (state_r == ST_WALK))
    else $error("walk ended before the row was done");
`endif

endmodule
